FILE: rtl/sifb_pkg.sv
// Shared types and constants for the stuffed information frame builder.
`default_nettype none
package sifb_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [7:0] STUFF_MASK = 8'h20;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CTL_SEQ0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTL_SEQ1 = 3'd4;

    // Output sequencer steps, in emission order.
    localparam int NUM_STEPS = 9;
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_OPEN_FLAG = 4'd0;
    localparam logic [STEP_W-1:0] ST_ADDRESS = 4'd1;
    localparam logic [STEP_W-1:0] ST_CONTROL = 4'd2;
    localparam logic [STEP_W-1:0] ST_HDR_CHECK = 4'd3;
    localparam logic [STEP_W-1:0] ST_DATA_ESC = 4'd4;
    localparam logic [STEP_W-1:0] ST_DATA = 4'd5;
    localparam logic [STEP_W-1:0] ST_CHK_ESC = 4'd6;
    localparam logic [STEP_W-1:0] ST_CHK = 4'd7;
    localparam logic [STEP_W-1:0] ST_CLOSE_FLAG = 4'd8;

    typedef struct packed {
        logic [7:0] flag;
        logic [7:0] escape;
        logic [7:0] address;
        logic [7:0] ctl_seq0;
        logic [7:0] ctl_seq1;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] ctl;
        logic [7:0] chk;
        logic       first;
        logic       last;
        logic       data_esc;
        logic       chk_esc;
    } t_entry;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/sifb_queue.sv
// Short request queue between the classifier and the output sequencer.
`default_nettype none
module sifb_queue
    import sifb_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr,
    input  wire t_entry i_wr_entry,
    input  wire logic   i_rd,
    output t_entry      o_head,
    output logic        o_valid,
    output logic        o_full
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

    t_entry r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    assign o_head = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full = (r_count == FullCnt);

endmodule
`default_nettype wire

FILE: rtl/sifb_front.sv
// Input side: takes payload bytes, keeps the running check and classifies stuffing.
`default_nettype none
module sifb_front
    import sifb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_seq_bit,
    output t_entry          o_entry
);

    logic [7:0] r_chk, n_chk;

    always_comb begin
        n_chk = (i_first_byte ? 8'h00 : r_chk) ^ i_data_byte;
        o_entry.data = i_data_byte;
        o_entry.ctl = i_seq_bit ? i_cfg.ctl_seq1 : i_cfg.ctl_seq0;
        o_entry.chk = n_chk;
        o_entry.first = i_first_byte;
        o_entry.last = i_last_byte;
        o_entry.data_esc = (i_data_byte == i_cfg.flag) || (i_data_byte == i_cfg.escape);
        o_entry.chk_esc = (n_chk == i_cfg.flag) || (n_chk == i_cfg.escape);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= '0;
        end else if (i_accept) begin
            r_chk <= n_chk;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sifb_back.sv
// Output side: steps through the bytes of each request into the output register.
`default_nettype none
module sifb_back
    import sifb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire t_entry i_head,
    input  wire logic   i_head_valid,
    output logic        o_head_rd,
    input  wire logic   i_pop,
    output t_result     o_result,
    output logic        o_valid
);

    logic [STEP_W-1:0] r_step, n_step;
    logic [STEP_W-1:0] cur;
    logic [NUM_STEPS-1:0] step_en;
    logic more;
    logic emit;
    logic r_out_valid;
    t_result r_out, n_out;

    always_comb begin
        step_en = '0;
        step_en[ST_OPEN_FLAG] = i_head.first;
        step_en[ST_ADDRESS] = i_head.first;
        step_en[ST_CONTROL] = i_head.first;
        step_en[ST_HDR_CHECK] = i_head.first;
        step_en[ST_DATA_ESC] = i_head.data_esc;
        step_en[ST_DATA] = 1'b1;
        step_en[ST_CHK_ESC] = i_head.last && i_head.chk_esc;
        step_en[ST_CHK] = i_head.last;
        step_en[ST_CLOSE_FLAG] = i_head.last;

        cur = ST_DATA;
        for (int i = NUM_STEPS - 1; i >= 0; i--) begin
            if (step_en[i] && (STEP_W'(i) >= r_step)) begin
                cur = STEP_W'(i);
            end
        end
        more = 1'b0;
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (step_en[i] && (STEP_W'(i) > cur)) begin
                more = 1'b1;
            end
        end
    end

    always_comb begin
        n_out.run_last = !more;
        n_out.frame_end = 1'b0;
        unique case (cur)
            ST_OPEN_FLAG: n_out.out_byte = i_cfg.flag;
            ST_ADDRESS: n_out.out_byte = i_cfg.address;
            ST_CONTROL: n_out.out_byte = i_head.ctl;
            ST_HDR_CHECK: n_out.out_byte = i_cfg.address ^ i_head.ctl;
            ST_DATA_ESC: n_out.out_byte = i_cfg.escape;
            ST_DATA: n_out.out_byte = i_head.data_esc ? (i_head.data ^ STUFF_MASK) : i_head.data;
            ST_CHK_ESC: n_out.out_byte = i_cfg.escape;
            ST_CHK: n_out.out_byte = i_head.chk_esc ? (i_head.chk ^ STUFF_MASK) : i_head.chk;
            ST_CLOSE_FLAG: begin
                n_out.out_byte = i_cfg.flag;
                n_out.frame_end = 1'b1;
            end
            default: n_out.out_byte = i_cfg.flag;
        endcase
    end

    assign emit = i_head_valid && (!r_out_valid || i_pop);
    assign o_head_rd = emit && !more;

    always_comb begin
        n_step = r_step;
        if (emit) begin
            n_step = more ? cur + 1'b1 : ST_OPEN_FLAG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_OPEN_FLAG;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;
    assign o_valid = r_out_valid;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_end |-> r_out.run_last)
        else $error("closing flag not marked as last byte of request");

    a_retire_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_head_rd |=> r_out_valid && r_out.run_last)
        else $error("request retired without a last byte");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= ST_CLOSE_FLAG)
        else $error("sequencer step out of range");

    a_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !emit |=> $stable(r_step))
        else $error("sequencer moved without emitting");

endmodule
`default_nettype wire

FILE: rtl/stuffed_info_frame_builder.sv
// Top level of the byte-stuffing information frame builder with XOR check byte.
// Each accepted payload byte becomes 1 to 9 line bytes (header on a first byte,
// escape prefix on stuffed bytes, check byte and closing flag on a last byte).
// The output sequencer emits one line byte per clock while its output register is
// free or being popped, and retires a request with its last line byte. Input is
// taken every cycle while the request queue between classifier and sequencer has
// room (QueueDepth entries), and the output register lets a new byte be loaded in
// the cycle it is popped.
// Configuration must be written only while the block is idle.
`default_nettype none
module stuffed_info_frame_builder
    import sifb_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]           i_cfg_wdata,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_first_byte,
    input  wire logic                 i_last_byte,
    input  wire logic                 i_seq_bit,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [7:0]                o_out_byte,
    output logic                      o_run_last,
    output logic                      o_frame_end
);

    t_cfg r_cfg;
    t_entry wr_entry, head;
    t_result result;
    logic accept, head_valid, head_rd, q_full, out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag <= 8'h7E;
            r_cfg.escape <= 8'h7D;
            r_cfg.address <= 8'h03;
            r_cfg.ctl_seq0 <= 8'h00;
            r_cfg.ctl_seq1 <= 8'h40;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FLAG: r_cfg.flag <= i_cfg_wdata;
                REG_ESCAPE: r_cfg.escape <= i_cfg_wdata;
                REG_ADDRESS: r_cfg.address <= i_cfg_wdata;
                REG_CTL_SEQ0: r_cfg.ctl_seq0 <= i_cfg_wdata;
                REG_CTL_SEQ1: r_cfg.ctl_seq1 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign accept = push && !q_full;

    sifb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_seq_bit    (i_seq_bit),
        .o_entry      (wr_entry)
    );

    sifb_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (accept),
        .i_wr_entry (wr_entry),
        .i_rd       (head_rd),
        .o_head     (head),
        .o_valid    (head_valid),
        .o_full     (q_full)
    );

    sifb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_head_rd    (head_rd),
        .i_pop        (pop),
        .o_result     (result),
        .o_valid      (out_valid)
    );

    assign full = q_full;
    assign empty = !out_valid;
    assign o_out_byte = result.out_byte;
    assign o_run_last = result.run_last;
    assign o_frame_end = result.frame_end;

endmodule
`default_nettype wire

FILE: tb/sifb_checker.sv
// Checker for the stuffed frame builder: predicts the line bytes of each request and compares.
module sifb_checker
    import sifb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_first_byte,
    input  logic                 i_last_byte,
    input  logic                 i_seq_bit,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  logic [7:0]           i_out_byte,
    input  logic                 i_run_last,
    input  logic                 i_frame_end,
    output int                   o_lines_due,
    output int                   o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] FLAG_RESET     = 8'h7E;
    localparam logic [7:0] ESCAPE_RESET   = 8'h7D;
    localparam logic [7:0] ADDRESS_RESET  = 8'h03;
    localparam logic [7:0] CTL_SEQ0_RESET = 8'h00;
    localparam logic [7:0] CTL_SEQ1_RESET = 8'h40;

    t_cfg       cfg_now;
    logic [7:0] check_accum;
    t_result    line_due[$];
    t_result    seen;
    t_result    want;

    function automatic void put_line(input logic [7:0] value, input logic closing);
        t_result r;
        r.out_byte  = value;
        r.run_last  = 1'b0;
        r.frame_end = closing;
        line_due.push_back(r);
    endfunction

    function automatic void put_stuffed(input logic [7:0] value);
        if (value == cfg_now.flag || value == cfg_now.escape) begin
            put_line(cfg_now.escape, 1'b0);
            put_line(value ^ STUFF_MASK, 1'b0);
        end else begin
            put_line(value, 1'b0);
        end
    endfunction

    function automatic void frame_request(input logic [7:0] d, input logic f, input logic l,
                                          input logic s);
        logic [7:0] ctl;
        t_result    tail;
        if (f) begin
            ctl = s ? cfg_now.ctl_seq1 : cfg_now.ctl_seq0;
            check_accum = 8'h00;
            put_line(cfg_now.flag, 1'b0);
            put_line(cfg_now.address, 1'b0);
            put_line(ctl, 1'b0);
            put_line(cfg_now.address ^ ctl, 1'b0);
        end
        check_accum = check_accum ^ d;
        put_stuffed(d);
        if (l) begin
            put_stuffed(check_accum);
            put_line(cfg_now.flag, 1'b1);
        end
        tail = line_due.pop_back();
        tail.run_last = 1'b1;
        line_due.push_back(tail);
    endfunction

    initial begin
        o_mismatches = 0;
        o_lines_due  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_now.flag     = FLAG_RESET;
            cfg_now.escape   = ESCAPE_RESET;
            cfg_now.address  = ADDRESS_RESET;
            cfg_now.ctl_seq0 = CTL_SEQ0_RESET;
            cfg_now.ctl_seq1 = CTL_SEQ1_RESET;
            check_accum = 8'h00;
            line_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                seen.out_byte  = i_out_byte;
                seen.run_last  = i_run_last;
                seen.frame_end = i_frame_end;
                if (line_due.size() == 0) begin
                    $display("%0t: unexpected line byte %02h run_last %b frame_end %b",
                             $time, seen.out_byte, seen.run_last, seen.frame_end);
                    o_mismatches++;
                end else begin
                    want = line_due.pop_front();
                    if (seen.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want.out_byte, seen.out_byte);
                        o_mismatches++;
                    end
                    if (seen.run_last !== want.run_last) begin
                        $display("%0t: run_last mismatch, expected %b, actual %b",
                                 $time, want.run_last, seen.run_last);
                        o_mismatches++;
                    end
                    if (seen.frame_end !== want.frame_end) begin
                        $display("%0t: frame_end mismatch, expected %b, actual %b",
                                 $time, want.frame_end, seen.frame_end);
                        o_mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FLAG:     cfg_now.flag     = i_cfg_wdata;
                    REG_ESCAPE:   cfg_now.escape   = i_cfg_wdata;
                    REG_ADDRESS:  cfg_now.address  = i_cfg_wdata;
                    REG_CTL_SEQ0: cfg_now.ctl_seq0 = i_cfg_wdata;
                    REG_CTL_SEQ1: cfg_now.ctl_seq1 = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                frame_request(i_data_byte, i_first_byte, i_last_byte, i_seq_bit);
            end
        end
        o_lines_due = line_due.size();
    end

endmodule

FILE: tb/tb_stuffed_info_frame_builder.sv
// Testbench top for the stuffed frame builder: reset, register setup, frame traffic, verdict.
module tb_stuffed_info_frame_builder
    import sifb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 20;

    typedef enum int {
        DRAIN_ALL,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } t_pop_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [7:0]           cfg_wdata;
    logic                 push;
    logic                 full;
    logic [7:0]           data_byte;
    logic                 first_byte;
    logic                 last_byte;
    logic                 seq_bit;
    logic                 empty;
    logic                 pop;
    logic [7:0]           out_byte;
    logic                 run_last;
    logic                 frame_end;

    int         lines_due;
    int         mismatches;
    int         cycle_count = 0;
    int         burst_left = 0;
    bit         hold_req = 1'b0;
    bit         hold_taken = 1'b0;
    logic [7:0] cur_flag = 8'h7E;
    logic [7:0] cur_escape = 8'h7D;

    stuffed_info_frame_builder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .push         (push),
        .full         (full),
        .i_data_byte  (data_byte),
        .i_first_byte (first_byte),
        .i_last_byte  (last_byte),
        .i_seq_bit    (seq_bit),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (out_byte),
        .o_run_last   (run_last),
        .o_frame_end  (frame_end)
    );

    sifb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_push       (push),
        .i_full       (full),
        .i_data_byte  (data_byte),
        .i_first_byte (first_byte),
        .i_last_byte  (last_byte),
        .i_seq_bit    (seq_bit),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_byte   (out_byte),
        .i_run_last   (run_last),
        .i_frame_end  (frame_end),
        .o_lines_due  (lines_due),
        .o_mismatches (mismatches)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one request and returns at the edge that accepts it; push stays up within a burst.
    task automatic send_byte(input logic [7:0] d, input logic f, input logic l, input logic s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        push       <= 1'b1;
        data_byte  <= d;
        first_byte <= f;
        last_byte  <= l;
        seq_bit    <= s;
        do @(posedge i_clk); while (full);
    endtask

    // Called right at the accepting edge: drops push and waits for the line stream to drain.
    task automatic settle();
        push <= 1'b0;
        burst_left = 0;
        do repeat (2) @(posedge i_clk); while (lines_due != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] flag, input logic [7:0] esc,
                                input logic [7:0] addr, input logic [7:0] ctl0,
                                input logic [7:0] ctl1);
        logic [CFG_IDX_W-1:0] idx_list[6];
        logic [7:0]           val_list[6];
        idx_list = '{REG_FLAG, REG_ESCAPE, REG_ADDRESS, REG_CTL_SEQ0, REG_CTL_SEQ1, REG_UNUSED};
        val_list = '{flag, esc, addr, ctl0, ctl1, 8'($urandom_range(0, 255))};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= idx_list[i];
            cfg_wdata <= val_list[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        cur_flag   = flag;
        cur_escape = esc;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0: return cur_flag;
            1: return cur_escape;
            2: return cur_flag ^ STUFF_MASK;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Well-formed frame; the last byte sometimes steers the check byte onto flag or escape.
    task automatic send_frame(input int n, input logic s);
        logic [7:0] chk;
        logic [7:0] d;
        chk = 8'h00;
        for (int i = 0; i < n; i++) begin
            d = pick_payload();
            if (i == n - 1 && $urandom_range(0, 3) == 0) begin
                d = chk ^ (($urandom_range(0, 1) == 0) ? cur_flag : cur_escape);
            end
            send_byte(d, i == 0, i == n - 1, s);
            chk = chk ^ d;
        end
    endtask

    task automatic random_traffic(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
                send_frame(len, 1'($urandom_range(0, 1)));
                sent += len;
            end
        end
    endtask

    initial begin
        t_pop_mode mode;
        int        seg;
        pop <= 1'b0;
        forever begin
            mode = t_pop_mode'($urandom_range(0, 3));
            seg  = $urandom_range(10, 80);
            for (int k = 0; k < seg; k++) begin
                @(posedge i_clk);
                if (hold_req && !hold_taken) begin
                    pop <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    hold_taken = 1'b1;
                end else begin
                    case (mode)
                        DRAIN_ALL:   pop <= 1'b1;
                        STALL_LIGHT: pop <= ($urandom_range(0, 3) != 0);
                        STALL_HEAVY: pop <= ($urandom_range(0, 3) == 0);
                        default:     pop <= k[0];
                    endcase
                end
            end
        end
    end

    initial begin
        logic [7:0] same;
        i_rst_n    <= 1'b0;
        push       <= 1'b0;
        data_byte  <= 8'h00;
        first_byte <= 1'b0;
        last_byte  <= 1'b0;
        seq_bit    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_idx    <= REG_FLAG;
        cfg_wdata  <= 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: one-byte frames, stuffed payload, escaped check byte
        send_byte(8'h00, 1'b1, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
        send_byte(8'h7E, 1'b1, 1'b0, 1'b0);
        send_byte(8'h7D, 1'b0, 1'b0, 1'b0);
        send_byte(8'h5E, 1'b0, 1'b0, 1'b0);
        send_byte(8'h23, 1'b0, 1'b1, 1'b0);
        // bytes after a closed frame keep accumulating with no header
        send_byte(8'h7E, 1'b0, 1'b0, 1'b1);
        send_byte(8'h41, 1'b0, 1'b1, 1'b0);
        send_byte(8'h7D, 1'b1, 1'b1, 1'b1);
        // frame restarted before its end
        send_byte(8'h10, 1'b1, 1'b0, 1'b1);
        send_byte(8'h20, 1'b1, 1'b0, 1'b0);
        send_byte(8'h5D, 1'b0, 1'b1, 1'b1);
        settle();

        // flag equal to escape
        write_config(8'h55, 8'h55, 8'hFF, 8'h00, 8'hFF);
        send_byte(8'h55, 1'b1, 1'b1, 1'b0);
        send_byte(8'h75, 1'b1, 1'b0, 1'b1);
        send_byte(8'h20, 1'b0, 1'b1, 1'b0);
        settle();

        write_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_byte(8'h00, 1'b1, 1'b1, 1'b0);
        send_byte(8'h80, 1'b1, 1'b0, 1'b1);
        send_byte(8'h80, 1'b0, 1'b1, 1'b0);
        settle();

        write_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
        send_byte(8'h01, 1'b1, 1'b0, 1'b0);
        send_byte(8'hFE, 1'b0, 1'b1, 1'b1);
        settle();

        write_config(8'h7E, 8'h7D, 8'h03, 8'h00, 8'h40);
        random_traffic(45);
        settle();

        write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        hold_req = 1'b1;
        random_traffic(45);
        settle();

        same = 8'($urandom_range(0, 255));
        write_config(same, same, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        random_traffic(45);
        settle();

        write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        random_traffic(45);
        settle();

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: stuffed_info_frame_builder.f
rtl/sifb_pkg.sv
rtl/sifb_queue.sv
rtl/sifb_front.sv
rtl/sifb_back.sv
rtl/stuffed_info_frame_builder.sv
tb/sifb_checker.sv
tb/tb_stuffed_info_frame_builder.sv
